### rtl/rfbc_pkg.sv
package rfbc_pkg;

   localparam int GATES_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int POS_W = 9;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_TOP = 16'h8000;

   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h55;
   localparam logic [7:0] TYPE_RESULT = 8'h01;

   // positions in the output sequence of one item
   localparam logic [2:0] SEQ_SYNC_A = 3'd0;
   localparam logic [2:0] SEQ_SYNC_B = 3'd1;
   localparam logic [2:0] SEQ_LEN_LO = 3'd2;
   localparam logic [2:0] SEQ_LEN_HI = 3'd3;
   localparam logic [2:0] SEQ_TYPE = 3'd4;
   localparam logic [2:0] SEQ_DATA = 3'd5;
   localparam logic [2:0] SEQ_CRC_LO = 3'd6;
   localparam logic [2:0] SEQ_CRC_HI = 3'd7;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first;
      logic        last;
      logic [15:0] crc;
   } rfbc_entry_type;

   // crc16-ccitt, msb first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_val,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = crc_val ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   localparam logic [15:0] CRC_AFTER_TYPE = crc_byte(CRC_INIT, TYPE_RESULT);

endpackage

### rtl/rfbc_front.sv
module rfbc_front #(
   parameter int GATES = rfbc_pkg::GATES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              data_byte,
   input  logic                    queue_full,
   output logic                    entry_push,
   output rfbc_pkg::rfbc_entry_type entry
);
   import rfbc_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(33 + 4 * GATES - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic             accept;
   logic             is_first, is_last;
   logic [15:0]      crc_base, crc_next;

   assign accept = push && !queue_full;
   assign is_first = (pos_ff == '0);
   assign is_last = (pos_ff == LAST_POS);

   // start of frame folds the type byte in before the payload byte
   assign crc_base = is_first ? CRC_AFTER_TYPE : crc_ff;
   assign crc_next = crc_byte(crc_base, data_byte);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (accept) begin
         if (is_last) begin
            pos_in = '0;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_ff + 1'b1;
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   assign entry_push = accept;
   assign entry.data_byte = data_byte;
   assign entry.first = is_first;
   assign entry.last = is_last;
   assign entry.crc = crc_next;

endmodule

### rtl/rfbc_queue.sv
module rfbc_queue #(
   parameter int DEPTH = rfbc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rfbc_pkg::rfbc_entry_type wr_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output rfbc_pkg::rfbc_entry_type rd_entry
);
   import rfbc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rfbc_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   assign rd_entry = mem_ff[rd_ptr_ff];

endmodule

### rtl/rfbc_back.sv
module rfbc_back #(
   parameter int GATES = rfbc_pkg::GATES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rfbc_pkg::rfbc_entry_type head,
   input  logic                    head_empty,
   output logic                    head_pop,
   input  logic                    pop,
   output logic [7:0]              out_byte,
   output logic                    last_of_run,
   output logic                    frame_end
);
   import rfbc_pkg::*;

   localparam logic [15:0] LEN_FIELD = 16'(34 + 4 * GATES);

   logic [2:0] offset_ff, offset_in;
   logic [2:0] seq, final_seq;
   logic       step, at_final;

   assign seq = (head.first ? SEQ_SYNC_A : SEQ_DATA) + offset_ff;
   assign final_seq = head.last ? SEQ_CRC_HI : SEQ_DATA;
   assign at_final = (seq == final_seq);
   assign step = pop && !head_empty;
   assign head_pop = step && at_final;

   always_comb begin
      offset_in = offset_ff;
      if (step) begin
         offset_in = at_final ? 3'd0 : offset_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 3'd0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      case (seq)
         SEQ_SYNC_A: out_byte = SYNC_A;
         SEQ_SYNC_B: out_byte = SYNC_B;
         SEQ_LEN_LO: out_byte = LEN_FIELD[7:0];
         SEQ_LEN_HI: out_byte = LEN_FIELD[15:8];
         SEQ_TYPE:   out_byte = TYPE_RESULT;
         SEQ_DATA:   out_byte = head.data_byte;
         SEQ_CRC_LO: out_byte = head.crc[7:0];
         SEQ_CRC_HI: out_byte = head.crc[15:8];
         default:    out_byte = head.data_byte;
      endcase
   end

   assign last_of_run = at_final;
   assign frame_end = (seq == SEQ_CRC_HI);

endmodule

### rtl/result_frame_builder_crc16.sv
// result_frame_builder_crc16: frames result records for a byte-serial link.
// req side: present one payload byte on req_data_byte with req_push; the
// byte is taken at a clock edge where req_push is high and req_full is low.
// rsp side: while rsp_empty is low the next framed byte sits on rsp_out_byte,
// with rsp_last_of_run marking the final byte an item causes and
// rsp_frame_end marking the crc high byte; rsp_pop takes it.
// a frame starts with aa 55, the body length (low, high) and type 01 before
// the first payload byte, and ends with the crc16 (low, high) after the last.
// an accepted item is registered into the queue; its first output byte is
// shown at the queue head. throughput: one item per cycle while req_full is
// low; middle bytes give one output each, the first byte of a frame six and
// the last three, so the rsp side sets the pace over a frame. the input side
// accepts until the item queue between the crc/position stage and the
// output sequencer (QUEUE_DEPTH entries) fills; while the receiver stalls,
// rsp ports hold and req_full rises. reset clears the queue, the byte
// position and the running crc, so the next byte accepted opens a new frame.
module result_frame_builder_crc16 #(
   parameter int GATES = rfbc_pkg::GATES_DEFAULT,
   parameter int QUEUE_DEPTH = rfbc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_frame_end
);
   import rfbc_pkg::*;

   rfbc_entry_type wr_entry, head;
   logic           entry_push, head_pop, queue_full, queue_empty;

   rfbc_front #(
      .GATES(GATES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .data_byte(req_data_byte),
      .queue_full(queue_full),
      .entry_push(entry_push),
      .entry(wr_entry)
   );

   rfbc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(entry_push),
      .wr_entry(wr_entry),
      .full(queue_full),
      .pop(head_pop),
      .empty(queue_empty),
      .rd_entry(head)
   );

   rfbc_back #(
      .GATES(GATES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_empty(queue_empty),
      .head_pop(head_pop),
      .pop(rsp_pop),
      .out_byte(rsp_out_byte),
      .last_of_run(rsp_last_of_run),
      .frame_end(rsp_frame_end)
   );

   assign req_full = queue_full;
   assign rsp_empty = queue_empty;

endmodule
